### hdl/trm_pkg.sv
`timescale 1ns / 1ps

package trm_pkg;

    // Averaging ring
    localparam int AVG_DEPTH  = 5;
    localparam int RING_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W      = 16 + $clog2(AVG_DEPTH + 1);

    // Divide by AVG_DEPTH as a multiply by the rounded-up reciprocal; four extra
    // bits of scale keep the quotient exact over the whole sum range
    localparam int AVG_SH      = SUM_W + 4;
    localparam int AVG_RECIP_W = AVG_SH + 1;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'((2 ** AVG_SH + AVG_DEPTH - 1) / AVG_DEPTH);

    // 60000 taps/min scaled to Q8.8
    localparam int          RATE_NUM_W  = 24;
    localparam logic [23:0] RATE_NUM_Q8 = 24'd15360000;

    // Shared divider
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 5;

    // Configuration port
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_TH_HIGH    = 3'd0;
    localparam logic [2:0] REG_TH_LOW     = 3'd1;
    localparam logic [2:0] REG_MIN_GAP    = 3'd2;
    localparam logic [2:0] REG_FADE_START = 3'd3;
    localparam logic [2:0] REG_FADE_END   = 3'd4;
    localparam logic [2:0] REG_RATE_CAP   = 3'd5;

    localparam logic signed [15:0] TH_HIGH_RST    = 16'sd32767;
    localparam logic signed [15:0] TH_LOW_RST     = -16'sd32768;
    localparam logic [15:0]        MIN_GAP_RST    = 16'd250;
    localparam logic [15:0]        FADE_START_RST = 16'd3000;
    localparam logic [15:0]        FADE_END_RST   = 16'd5000;
    localparam logic [7:0]         RATE_CAP_RST   = 8'd200;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic [7:0] taps_per_minute;
        logic       tap_seen;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RATE_DIV,
        S_SUM,
        S_AVG,
        S_FADE,
        S_FADE_MUL,
        S_FADE_DIV,
        S_DONE
    } state_t;

endpackage

### hdl/tap_rate_meter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  item (sample, now_ms)
// result    out        result_valid/result_stall result (taps_per_minute, tap_seen)
// config    in         APB psel/penable       paddr/pwdata/prdata, pready tied high
//
// One item at a time through a sequencer around one restoring divider (1 bit/cycle).
// No tap: CHECK, FADE and DONE, plus FADE_MUL and FADE_DIV (32 divider steps)
// when the fade division runs. Tap: adds RATE_DIV (24 steps, 60000/interval;
// none at zero interval), SUM over AVG_DEPTH entries, AVG by reciprocal multiply.
// Reset clears the control state and the ring at once; no clearing pass.
// A finished result waits in the output register; only the next item's
// delivery waits on result_stall.

module tap_rate_meter
    import trm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic signed [15:0] th_high_reg;
    logic signed [15:0] th_low_reg;
    logic [15:0]        min_gap_reg;
    logic [15:0]        fade_start_reg;
    logic [15:0]        fade_end_reg;
    logic [7:0]         rate_cap_reg;

    // Control and state
    state_t                state_reg, state_next;
    logic [15:0]           ring_reg [AVG_DEPTH];
    logic [15:0]           ring_next [AVG_DEPTH];
    logic [RING_IDX_W-1:0] ring_idx_reg, ring_idx_next;
    logic                  blocked_reg, blocked_next;
    logic [31:0]           last_tap_reg, last_tap_next;
    logic [15:0]           held_reg, held_next;
    logic                  result_valid_reg, result_valid_next;

    // Working registers
    logic signed [15:0]    sample_reg, sample_next;
    logic [31:0]           now_reg, now_next;
    logic                  tap_reg, tap_next;
    logic [15:0]           rate_reg, rate_next;
    logic [31:0]           prod_reg, prod_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [RING_IDX_W-1:0] sum_cnt_reg, sum_cnt_next;
    result_t               result_reg, result_next;

    // Divider
    logic [DIV_W-1:0]     div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]     div_dvd_reg, div_dvd_next;
    logic [DIV_W-1:0]     div_dsr_reg, div_dsr_next;
    logic [DIV_W-1:0]     div_q_reg, div_q_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [DIV_W:0]        div_trial;
    logic                  div_qbit;
    logic [DIV_W-1:0]      div_rem_step;
    logic [DIV_W-1:0]      div_q_final;
    logic                  div_done;

    logic                  cfg_wr;
    logic [31:0]           elapsed_c;
    logic                  tap_c;
    logic [31:0]           idle_c;
    logic [15:0]           fade_diff_c;
    logic [31:0]           prod_c;
    logic [SUM_W-1:0]      sum_acc_c;
    logic [RING_IDX_W-1:0] ring_idx_inc;
    logic [15:0]           entry_c;
    logic [15:0]           cap_q_c;
    logic [SUM_W+AVG_RECIP_W-1:0] avg_prod_c;
    logic [15:0]           avg_c;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_high_reg    <= TH_HIGH_RST;
            th_low_reg     <= TH_LOW_RST;
            min_gap_reg    <= MIN_GAP_RST;
            fade_start_reg <= FADE_START_RST;
            fade_end_reg   <= FADE_END_RST;
            rate_cap_reg   <= RATE_CAP_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_TH_HIGH:    th_high_reg    <= pwdata[15:0];
                REG_TH_LOW:     th_low_reg     <= pwdata[15:0];
                REG_MIN_GAP:    min_gap_reg    <= pwdata[15:0];
                REG_FADE_START: fade_start_reg <= pwdata[15:0];
                REG_FADE_END:   fade_end_reg   <= pwdata[15:0];
                REG_RATE_CAP:   rate_cap_reg   <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_TH_HIGH:    prdata = {16'b0, th_high_reg};
            REG_TH_LOW:     prdata = {16'b0, th_low_reg};
            REG_MIN_GAP:    prdata = {16'b0, min_gap_reg};
            REG_FADE_START: prdata = {16'b0, fade_start_reg};
            REG_FADE_END:   prdata = {16'b0, fade_end_reg};
            REG_RATE_CAP:   prdata = {24'b0, rate_cap_reg};
            default:        prdata = 32'b0;
        endcase
    end

    // ---------------- datapath helpers ----------------
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // restoring division step, one quotient bit per cycle
    assign div_trial    = {div_rem_reg, div_dvd_reg[DIV_W-1]} - {1'b0, div_dsr_reg};
    assign div_qbit     = ~div_trial[DIV_W];
    assign div_rem_step = div_qbit ? div_trial[DIV_W-1:0]
                                   : {div_rem_reg[DIV_W-2:0], div_dvd_reg[DIV_W-1]};
    assign div_q_final  = {div_q_reg[DIV_W-2:0], div_qbit};
    assign div_done     = (div_cnt_reg == '0);

    assign elapsed_c = now_reg - last_tap_reg;
    assign tap_c     = (sample_reg >= th_high_reg) && !blocked_reg
                       && (elapsed_c >= {16'b0, min_gap_reg});
    assign idle_c    = now_reg - last_tap_reg;

    // only used when idle < fade_end, so idle fits 16 bits
    assign fade_diff_c = fade_end_reg - idle_c[15:0];
    assign prod_c      = held_reg * fade_diff_c;

    assign sum_acc_c    = sum_reg + SUM_W'(ring_reg[sum_cnt_reg]);
    assign ring_idx_inc = (ring_idx_reg == RING_IDX_W'(AVG_DEPTH - 1))
                          ? '0 : ring_idx_reg + 1'b1;
    assign entry_c      = (div_q_final > 32'h0000_FFFF) ? 16'hFFFF : div_q_final[15:0];
    assign cap_q_c      = {rate_cap_reg, 8'b0};

    // integer part of the ring sum, back in Q8.8, divided by AVG_DEPTH
    assign avg_prod_c = {sum_reg[SUM_W-1:8], 8'b0} * AVG_RECIP;
    assign avg_c      = avg_prod_c[AVG_SH +: 16];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next        = state_reg;
        ring_next         = ring_reg;
        ring_idx_next     = ring_idx_reg;
        blocked_next      = blocked_reg;
        last_tap_next     = last_tap_reg;
        held_next         = held_reg;
        result_valid_next = result_valid_reg;
        sample_next       = sample_reg;
        now_next          = now_reg;
        tap_next          = tap_reg;
        rate_next         = rate_reg;
        prod_next         = prod_reg;
        sum_next          = sum_reg;
        sum_cnt_next      = sum_cnt_reg;
        result_next       = result_reg;
        div_rem_next      = div_rem_reg;
        div_dvd_next      = div_dvd_reg;
        div_dsr_next      = div_dsr_reg;
        div_q_next        = div_q_reg;
        div_cnt_next      = div_cnt_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    sample_next = item.sample;
                    now_next    = item.now_ms;
                    state_next  = S_CHECK;
                end
            end

            S_CHECK:
            begin
                tap_next = tap_c;
                // tap check first, rearm second: one sample may do both
                if (sample_reg <= th_low_reg)
                begin
                    blocked_next = 1'b0;
                end
                else if (tap_c)
                begin
                    blocked_next = 1'b1;
                end

                if (tap_c)
                begin
                    last_tap_next = now_reg;
                    if (elapsed_c == 32'b0)
                    begin
                        // zero interval saturates the entry
                        ring_next[ring_idx_reg] = 16'hFFFF;
                        ring_idx_next = ring_idx_inc;
                        sum_next      = '0;
                        sum_cnt_next  = '0;
                        state_next    = S_SUM;
                    end
                    else
                    begin
                        div_rem_next = '0;
                        div_q_next   = '0;
                        div_dvd_next = {RATE_NUM_Q8, {(DIV_W - RATE_NUM_W){1'b0}}};
                        div_dsr_next = elapsed_c;
                        div_cnt_next = DIV_CNT_W'(RATE_NUM_W - 1);
                        state_next   = S_RATE_DIV;
                    end
                end
                else
                begin
                    state_next = S_FADE;
                end
            end

            S_RATE_DIV:
            begin
                div_rem_next = div_rem_step;
                div_q_next   = div_q_final;
                div_dvd_next = {div_dvd_reg[DIV_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_done)
                begin
                    ring_next[ring_idx_reg] = entry_c;
                    ring_idx_next = ring_idx_inc;
                    sum_next      = '0;
                    sum_cnt_next  = '0;
                    state_next    = S_SUM;
                end
            end

            S_SUM:
            begin
                sum_next     = sum_acc_c;
                sum_cnt_next = sum_cnt_reg + 1'b1;
                if (sum_cnt_reg == RING_IDX_W'(AVG_DEPTH - 1))
                begin
                    state_next = S_AVG;
                end
            end

            S_AVG:
            begin
                // only the integer part of the sum is averaged
                if (avg_c >= cap_q_c)
                begin
                    held_next = cap_q_c;
                end
                else
                begin
                    held_next = avg_c;
                end
                state_next = S_FADE;
            end

            S_FADE:
            begin
                if (idle_c >= {16'b0, fade_start_reg})
                begin
                    if (idle_c >= {16'b0, fade_end_reg})
                    begin
                        rate_next  = '0;
                        held_next  = '0;
                        ring_next  = '{default: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        prod_next  = prod_c;
                        state_next = S_FADE_MUL;
                    end
                end
                else
                begin
                    rate_next  = held_reg;
                    state_next = S_DONE;
                end
            end

            S_FADE_MUL:
            begin
                // fade_end > fade_start here, so the divisor is nonzero
                div_rem_next = '0;
                div_q_next   = '0;
                div_dvd_next = prod_reg;
                div_dsr_next = {16'b0, fade_end_reg - fade_start_reg};
                div_cnt_next = DIV_CNT_W'(DIV_W - 1);
                state_next   = S_FADE_DIV;
            end

            S_FADE_DIV:
            begin
                div_rem_next = div_rem_step;
                div_q_next   = div_q_final;
                div_dvd_next = {div_dvd_reg[DIV_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_done)
                begin
                    rate_next = div_q_final[15:0];
                    if (div_q_final[15:8] == 8'b0)
                    begin
                        held_next = '0;
                        ring_next = '{default: '0};
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.taps_per_minute = rate_reg[15:8];
                    result_next.tap_seen        = tap_reg;
                    result_valid_next           = 1'b1;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ring_reg         <= '{default: '0};
            ring_idx_reg     <= '0;
            blocked_reg      <= 1'b0;
            last_tap_reg     <= '0;
            held_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ring_reg         <= ring_next;
            ring_idx_reg     <= ring_idx_next;
            blocked_reg      <= blocked_next;
            last_tap_reg     <= last_tap_next;
            held_reg         <= held_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        now_reg     <= now_next;
        tap_reg     <= tap_next;
        rate_reg    <= rate_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        sum_cnt_reg <= sum_cnt_next;
        result_reg  <= result_next;
        div_rem_reg <= div_rem_next;
        div_dvd_reg <= div_dvd_next;
        div_dsr_reg <= div_dsr_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
    end

endmodule

### verif/tap_rate_meter_checker.sv
`timescale 1ns / 1ps

module tap_rate_meter_checker
    import trm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  item_t              item,
    input  logic               result_valid,
    input  logic               result_stall,
    input  result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 pending,
    output int                 mismatches
);

    // settings as last written over the configuration port
    logic signed [15:0] th_high;
    logic signed [15:0] th_low;
    logic [15:0]        min_gap;
    logic [15:0]        fade_start;
    logic [15:0]        fade_end;
    logic [7:0]         rate_cap;

    // predicted meter state
    logic [15:0] ring [AVG_DEPTH];
    logic [31:0] slot;
    logic        blocked;
    logic [31:0] last_tap;
    logic [15:0] held;

    result_t expected_rates[$];
    int      errors = 0;
    int      result_no = 0;

    assign mismatches = errors;

    task automatic report_mismatch(input string what);
        $display("%0t ns: result %0d: %s", $time, result_no, what);
        errors++;
    endtask

    function automatic void clear_ring();
        int i;
        for (i = 0; i < AVG_DEPTH; i++)
            ring[i] = '0;
    endfunction

    function automatic result_t predict_rate(input item_t it);
        result_t     r;
        logic [31:0] elapsed;
        logic [31:0] quot;
        logic [31:0] entry;
        logic [31:0] total;
        logic [31:0] avg;
        logic [31:0] cap_q;
        logic [31:0] idle;
        logic [31:0] rate;
        logic [63:0] scaled;
        int          i;
        r = '0;
        elapsed = it.now_ms - last_tap;
        if ($signed(it.sample) >= th_high && !blocked && elapsed >= 32'(min_gap)) begin
            // 60000 taps/min in Q8.8 over the interval, saturating (also at zero)
            quot  = (elapsed == 0) ? 32'hFFFF_FFFF : 32'(RATE_NUM_Q8) / elapsed;
            entry = (quot > 32'hFFFF) ? 32'hFFFF : quot;
            if (slot >= AVG_DEPTH)
                slot = 0;
            ring[slot] = entry[15:0];
            slot = (slot + 1 >= AVG_DEPTH) ? 0 : slot + 1;
            total = 0;
            for (i = 0; i < AVG_DEPTH; i++)
                total += 32'(ring[i]);
            avg   = ((total >> 8) << 8) / 32'(AVG_DEPTH);
            cap_q = {16'd0, rate_cap, 8'd0};
            if (avg >= cap_q)
                avg = cap_q;
            held     = avg[15:0];
            last_tap = it.now_ms;
            blocked  = 1'b1;
            r.tap_seen = 1'b1;
        end
        // rearm is checked after the tap, so one sample can do both
        if ($signed(it.sample) <= th_low)
            blocked = 1'b0;

        rate = 32'(held);
        idle = it.now_ms - last_tap;
        if (idle >= 32'(fade_start)) begin
            if (idle >= 32'(fade_end)) begin
                rate = 0;
            end
            else begin
                scaled = 64'(held) * 64'(32'(fade_end) - idle);
                rate   = 32'(scaled / 64'(fade_end - fade_start));
            end
            if (rate[31:8] == 0) begin
                held = '0;
                clear_ring();
            end
        end
        r.taps_per_minute = rate[15:8];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            th_high    = TH_HIGH_RST;
            th_low     = TH_LOW_RST;
            min_gap    = MIN_GAP_RST;
            fade_start = FADE_START_RST;
            fade_end   = FADE_END_RST;
            rate_cap   = RATE_CAP_RST;
            clear_ring();
            slot     = 0;
            blocked  = 1'b0;
            last_tap = '0;
            held     = '0;
            expected_rates.delete();
            pending <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_TH_HIGH:    th_high    = pwdata[15:0];
                    REG_TH_LOW:     th_low     = pwdata[15:0];
                    REG_MIN_GAP:    min_gap    = pwdata[15:0];
                    REG_FADE_START: fade_start = pwdata[15:0];
                    REG_FADE_END:   fade_end   = pwdata[15:0];
                    REG_RATE_CAP:   rate_cap   = pwdata[7:0];
                    default: ;
                endcase
            end

            if (result_valid && !result_stall) begin
                if (expected_rates.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: rate %0d tap %0b",
                        result.taps_per_minute, result.tap_seen));
                end
                else begin
                    want = expected_rates.pop_front();
                    if (result.taps_per_minute !== want.taps_per_minute)
                        report_mismatch($sformatf("taps_per_minute %0d, expected %0d",
                            result.taps_per_minute, want.taps_per_minute));
                    if (result.tap_seen !== want.tap_seen)
                        report_mismatch($sformatf("tap_seen %0b, expected %0b",
                            result.tap_seen, want.tap_seen));
                end
                result_no++;
            end

            if (item_valid && !item_stall)
                expected_rates.push_back(predict_rate(item));

            pending <= expected_rates.size();
        end
    end

endmodule

### verif/tap_rate_meter_tb.sv
`timescale 1ns / 1ps

module tap_rate_meter_tb
    import trm_pkg::*;
();

    localparam logic [2:0]  REG_SPARE = 3'd6;   // decodes to no register
    localparam logic [15:0] LEVEL_MAX = 16'h7FFF;
    localparam logic [15:0] LEVEL_MIN = 16'h8000;
    localparam int          LONG_HOLD = 300;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    item_t              item;
    logic               result_valid;
    logic               result_stall;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 pending;
    int                 mismatches;

    // stimulus-side copy of the settings, for shaping sample levels and times
    int          cfg_th_high;
    int          cfg_th_low;
    int          cfg_min_gap;
    int          cfg_fade_start;
    int          cfg_fade_end;
    logic [31:0] now_cursor;
    bit          tx_burst;

    always #5 clk = ~clk;

    tap_rate_meter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tap_rate_meter_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    initial begin
        #10_000_000;
        $display("tap_rate_meter test failed");
        $finish;
    end

    // result side: random stalls, quiet stretches, and two long hold-offs
    initial begin : receiver
        int hold;
        int taken;
        bit rx_burst;
        taken    = 0;
        rx_burst = 1'b0;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(31) == 0)
                rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(15);
            if (taken == 150 || taken == 700)
                hold = LONG_HOLD;
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!(result_valid && !result_stall));
            taken++;
        end
    end

    task automatic send_item(input logic [15:0] level, input logic [31:0] stamp);
        int gap;
        if ($urandom_range(31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(15);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{sample: level, now_ms: stamp};
        do @(posedge clk); while (item_stall);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int th_high, th_low, min_gap, fade_start, fade_end,
                              cap);
        drain();
        write_reg(REG_TH_HIGH,    {16'($urandom), 16'(th_high)});
        write_reg(REG_TH_LOW,     {16'($urandom), 16'(th_low)});
        write_reg(REG_MIN_GAP,    {16'($urandom), 16'(min_gap)});
        write_reg(REG_FADE_START, {16'($urandom), 16'(fade_start)});
        write_reg(REG_FADE_END,   {16'($urandom), 16'(fade_end)});
        write_reg(REG_RATE_CAP,   {24'($urandom), 8'(cap)});
        cfg_th_high    = th_high;
        cfg_th_low     = th_low;
        cfg_min_gap    = min_gap;
        cfg_fade_start = fade_start;
        cfg_fade_end   = fade_end;
    endtask

    function automatic logic [15:0] high_level();
        if ($urandom_range(3) == 0)
            return 16'(cfg_th_high);
        return 16'(cfg_th_high + int'($urandom_range(32767 - cfg_th_high)));
    endfunction

    function automatic logic [15:0] low_level();
        if ($urandom_range(3) == 0)
            return 16'(cfg_th_low);
        return 16'(cfg_th_low - int'($urandom_range(cfg_th_low + 32768)));
    endfunction

    function automatic logic [15:0] mid_level();
        if (cfg_th_high - cfg_th_low > 1)
            return 16'(cfg_th_low + 1 + int'($urandom_range(cfg_th_high - cfg_th_low - 2)));
        return 16'($urandom);
    endfunction

    // mostly tap/rearm sequences on an advancing time base, plus idle gaps
    // into the fade window, noise, time jumps and stamps near the wrap
    task automatic random_items(input int count);
        int sent;
        int kind;
        int extra;
        int pick;
        int k;
        int fade_top;
        sent     = 0;
        fade_top = ((cfg_fade_end > cfg_fade_start) ? cfg_fade_end : cfg_fade_start) + 1000;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                if ($urandom_range(4) != 0)
                    now_cursor += cfg_min_gap + $urandom_range(1500);
                else
                    now_cursor += $urandom_range(cfg_min_gap + 50);
                send_item(high_level(), now_cursor);
                extra = $urandom_range(3, 1);
                for (k = 0; k < extra; k++) begin
                    now_cursor += $urandom_range(100);
                    pick = $urandom_range(9);
                    if (pick < 7)
                        send_item(low_level(), now_cursor);
                    else if (pick < 9)
                        send_item(mid_level(), now_cursor);
                    else
                        send_item(high_level(), now_cursor);
                end
                sent += extra + 1;
            end
            else if (kind < 75) begin
                now_cursor += $urandom_range(fade_top);
                send_item(mid_level(), now_cursor);
                sent++;
            end
            else if (kind < 88) begin
                send_item(16'($urandom), now_cursor + $urandom_range(50));
                sent++;
            end
            else if (kind < 94) begin
                now_cursor = $urandom;
                send_item(16'($urandom), now_cursor);
                sent++;
            end
            else begin
                now_cursor = 32'hFFFF_FFFF - $urandom_range(2000);
                send_item(high_level(), now_cursor);
                sent++;
            end
        end
    endtask

    initial begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        tx_burst       = 1'b0;
        now_cursor     = '0;
        cfg_th_high    = int'(TH_HIGH_RST);
        cfg_th_low     = int'(TH_LOW_RST);
        cfg_min_gap    = int'(MIN_GAP_RST);
        cfg_fade_start = int'(FADE_START_RST);
        cfg_fade_end   = int'(FADE_END_RST);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: only full-scale levels tap and rearm
        send_item(16'h0000, 32'd0);
        send_item(LEVEL_MAX, 32'd100);         // inside the minimum gap
        send_item(LEVEL_MAX, 32'd1000);        // first tap, timed from zero
        send_item(LEVEL_MAX, 32'd1500);        // still blocked
        send_item(LEVEL_MIN, 32'd1600);
        send_item(LEVEL_MAX, 32'd1800);
        send_item(LEVEL_MIN, 32'd1800);
        send_item(LEVEL_MAX, 32'd1900);
        send_item(LEVEL_MAX, 32'd2100);
        send_item(LEVEL_MIN, 32'd2150);
        send_item(LEVEL_MAX, 32'd2400);
        send_item(LEVEL_MIN, 32'd2400);
        send_item(LEVEL_MAX, 32'd2650);        // exactly the minimum gap
        send_item(LEVEL_MIN, 32'd2650);
        send_item(LEVEL_MAX, 32'd2900);        // ring wraps
        send_item(16'h7FFE, 32'd3000);         // one below the high level
        send_item(16'h0000, 32'd6400);         // fading
        send_item(16'h0000, 32'd7899);         // last step before zero
        send_item(16'h0000, 32'd7900);         // fade end clears the average
        send_item(LEVEL_MIN, 32'hFFFF_FE00);
        send_item(LEVEL_MAX, 32'hFFFF_FF00);
        send_item(LEVEL_MIN, 32'hFFFF_FF80);
        send_item(LEVEL_MAX, 32'h0000_0140);   // interval across the wrap
        now_cursor = 32'h0000_0140;
        random_items(100);

        set_config(8000, -8000, 250, 3000, 5000, 200);
        random_items(300);

        // every sample taps and rearms; equal stamps give a zero interval
        set_config(-32768, 32767, 0, 0, 1, 255);
        send_item(16'h0000, now_cursor);
        send_item(LEVEL_MIN, now_cursor);
        random_items(150);

        set_config(32767, -32768, 65535, 65535, 65535, 1);
        random_items(100);

        // fade end below fade start, cap of zero, and a write to no register
        set_config(0, -1, 1, 5000, 1000, 0);
        write_reg(REG_SPARE, $urandom);
        random_items(120);

        // equal thresholds: a sample at the level taps and rearms
        set_config(20000, 20000, 400, 1000, 9000, 120);
        random_items(300);

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("tap_rate_meter test passed");
        else
            $display("tap_rate_meter test failed");
        $finish;
    end

endmodule
